[design/amsd_pkg.sv]
`timescale 1ns / 1ps
package amsd_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // datapath widths: CORDIC x/y, CORDIC angle, gain multiplier operand/result
    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int MW = 50;
    localparam int PW = XW + 20;

    localparam int INT_SCALE    = 30;
    localparam int SMOOTH_SCALE = 22;

    localparam logic [31:0] CORDIC_KINV  = 32'd2608131496;
    localparam logic [17:0] SYNC_DC_GAIN = 18'd167772;
    localparam logic [17:0] ENV_DC_GAIN  = 18'd1678;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_INIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_ROT_X,
        ST_ROT_Y,
        ST_VEC,
        ST_MAG,
        ST_DIFF,
        ST_BETA,
        ST_ALPHA,
        ST_DC_MUL,
        ST_DC_ADD,
        ST_SMOOTH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_req_t;

    typedef struct packed {
        logic start;
        logic shift30;
    } mul_req_t;

    // atan(2^-k) in phase-word units, 2^32 per turn
    function automatic logic [31:0] atan_word(input logic [4:0] k);
        logic [31:0] w;
        unique case (k)
            5'd0:    w = 32'd536870912;
            5'd1:    w = 32'd316933406;
            5'd2:    w = 32'd167458907;
            5'd3:    w = 32'd85004756;
            5'd4:    w = 32'd42667331;
            5'd5:    w = 32'd21354465;
            5'd6:    w = 32'd10680862;
            5'd7:    w = 32'd5340245;
            5'd8:    w = 32'd2670163;
            5'd9:    w = 32'd1335087;
            5'd10:   w = 32'd667544;
            5'd11:   w = 32'd333772;
            5'd12:   w = 32'd166886;
            5'd13:   w = 32'd83443;
            5'd14:   w = 32'd41722;
            5'd15:   w = 32'd20861;
            5'd16:   w = 32'd10430;
            5'd17:   w = 32'd5215;
            5'd18:   w = 32'd2608;
            5'd19:   w = 32'd1304;
            5'd20:   w = 32'd652;
            5'd21:   w = 32'd326;
            5'd22:   w = 32'd163;
            5'd23:   w = 32'd81;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

[design/am_sync_demodulator.sv]
`timescale 1ns / 1ps
// Channel   Dir  tdata fields (low bit up)      Notes
// s_axis    in   in_i, in_q                     one complex sample per transfer
// m_axis    out  audio                          one audio sample per input
// cfg       in   mode..loop_beta by cfg_index   write only; the user writes while idle, block does not enforce it
//
// In synchronous mode each sample takes two CORDIC passes, six passes of
// the shared gain multiplier, and one step each for idle, DC multiply,
// DC update and output. Envelope mode takes one CORDIC pass, one multiply,
// DC, smoothing and output steps. Both modes share the CORDIC and the
// two-pass 32x32 multiplier.
// Reset sets loop state, configuration and output valid to defaults; the
// output register holds a finished sample while m_tready is low, and a
// new sample is taken meanwhile, but not finished until that one leaves.
module am_sync_demodulator #(
    parameter int SAMPLE_BITS   = amsd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = amsd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // in_i, in_q
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // audio
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    input  logic                                   cfg_we,
    input  logic [amsd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [31:0]                            cfg_data
);
    import amsd_pkg::*;

    localparam int OW       = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IN_SH    = INT_SCALE + 1 - SAMPLE_BITS;
    localparam int SYNC_SHR = INT_SCALE - (SAMPLE_BITS - 1);
    localparam int ENV_SH   = SMOOTH_SCALE - (SAMPLE_BITS - 1);
    localparam int ENV_SHR  = (ENV_SH > 0) ? ENV_SH : 0;
    localparam int ENV_SHL  = (ENV_SH < 0) ? -ENV_SH : 0;

    // configuration
    logic               mode_reg;
    logic signed [31:0] freq_low_reg, freq_high_reg;
    logic [31:0]        alpha_reg, beta_reg;

    // loop state
    logic signed [31:0] freq_reg;
    logic [31:0]        phase_reg;
    logic signed [31:0] dc_reg;
    logic signed [23:0] smooth_reg;

    // per-sample work registers
    logic signed [XW-1:0] si_reg, sq_reg, re_reg, im_reg, mag_reg;
    logic signed [MW-1:0] diff_reg;
    logic signed [PW-1:0] prod_reg;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] audio_reg;

    // shared units
    cordic_req_t          c_req;
    logic                 c_done;
    logic signed [XW-1:0] c_x, c_y;
    logic [31:0]          c_z;
    mul_req_t             m_req;
    logic                 m_done;
    logic signed [MW-1:0] m_v, m_r;
    logic [31:0]          m_g;

    logic                 in_fire;
    logic                 unit_done;
    logic                 c_state, m_state;
    logic                 out_free;

    logic [SAMPLE_BITS-1:0] in_i, in_q;
    logic signed [31:0]   ang;
    logic [31:0]          ang_abs;

    logic signed [50:0]   f_sum, f_clamp, step;
    logic signed [XW:0]   dc_d;
    logic [17:0]          dc_gain;
    logic signed [39:0]   dc_sum, sm_sum, sm_half, o_v;
    logic signed [39:0]   o_lim;
    logic [SAMPLE_BITS-1:0] o_sat;

    assign in_i    = s_tdata[SAMPLE_BITS-1:0];
    assign in_q    = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign ang     = $signed(c_z);
    assign ang_abs = ang[31] ? (32'd0 - c_z) : c_z;

    // CORDIC: rotate by minus the phase word, or vector to magnitude and angle
    assign c_state         = (state_reg == ST_ROT) || (state_reg == ST_VEC);
    assign c_req.start     = c_state && !issued_reg;
    assign c_req.vectoring = (state_reg == ST_VEC);

    amsd_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (c_req),
        .x_in    ((state_reg == ST_ROT || mode_reg) ? si_reg : re_reg),
        .y_in    ((state_reg == ST_ROT || mode_reg) ? sq_reg : im_reg),
        .z_in    (32'd0 - phase_reg),
        .done    (c_done),
        .x_out   (c_x),
        .y_out   (c_y),
        .z_out   (c_z)
    );

    // gain multiplier operand selection
    assign m_state = (state_reg == ST_ROT_X) || (state_reg == ST_ROT_Y) ||
                     (state_reg == ST_MAG) || (state_reg == ST_DIFF) ||
                     (state_reg == ST_BETA) || (state_reg == ST_ALPHA);
    assign m_req.start   = m_state && !issued_reg;
    assign m_req.shift30 = (state_reg == ST_DIFF);

    always_comb begin
        unique case (state_reg)
            ST_ROT_X: begin m_v = MW'(c_x); m_g = CORDIC_KINV; end
            ST_ROT_Y: begin m_v = MW'(c_y); m_g = CORDIC_KINV; end
            ST_MAG:   begin m_v = MW'(c_x); m_g = CORDIC_KINV; end
            ST_DIFF:  begin
                m_v = ang[31] ? -MW'(mag_reg) : MW'(mag_reg);
                m_g = ang_abs;
            end
            ST_BETA:  begin m_v = diff_reg;  m_g = beta_reg;  end
            ST_ALPHA: begin m_v = diff_reg;  m_g = alpha_reg; end
            default:  begin m_v = diff_reg;  m_g = alpha_reg; end
        endcase
    end

    amsd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (m_req),
        .v       (m_v),
        .g       (m_g),
        .done    (m_done),
        .r       (m_r)
    );

    assign unit_done = c_state ? c_done : m_done;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        if (c_state || m_state) begin
            if (unit_done) begin
                issued_next = 1'b0;
            end else if (!issued_reg) begin
                issued_next = 1'b1;
            end
        end
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = s_tready && mode_reg ? ST_VEC : ST_ROT;
            ST_ROT:    if (c_done) state_next = ST_ROT_X;
            ST_ROT_X:  if (m_done) state_next = ST_ROT_Y;
            ST_ROT_Y:  if (m_done) state_next = ST_VEC;
            ST_VEC:    if (c_done) state_next = ST_MAG;
            ST_MAG:    if (m_done) state_next = mode_reg ? ST_DC_MUL : ST_DIFF;
            ST_DIFF:   if (m_done) state_next = ST_BETA;
            ST_BETA:   if (m_done) state_next = ST_ALPHA;
            ST_ALPHA:  if (m_done) state_next = ST_DC_MUL;
            ST_DC_MUL: state_next = ST_DC_ADD;
            ST_DC_ADD: state_next = mode_reg ? ST_SMOOTH : ST_OUT;
            ST_SMOOTH: state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    // loop filter: clamp low first, then high
    always_comb begin
        f_sum   = 51'(freq_reg) + 51'(m_r);
        f_clamp = f_sum;
        if (f_clamp < 51'(freq_low_reg)) begin
            f_clamp = 51'(freq_low_reg);
        end
        if (f_clamp > 51'(freq_high_reg)) begin
            f_clamp = 51'(freq_high_reg);
        end
        step = 51'(freq_reg) + 51'(m_r);
    end

    // DC trackers and smoothing
    assign dc_gain = mode_reg ? ENV_DC_GAIN : SYNC_DC_GAIN;
    assign dc_d    = (XW+1)'(mode_reg ? mag_reg : re_reg) - (XW+1)'(dc_reg);

    always_comb begin
        dc_sum = 40'(dc_reg) + 40'(prod_reg >>> 24);
        if (dc_sum > 40'sd2147483647) begin
            dc_sum = 40'sd2147483647;
        end else if (dc_sum < -40'sd2147483648) begin
            dc_sum = -40'sd2147483648;
        end
        sm_sum  = 40'(smooth_reg) + ((40'(mag_reg) - 40'(dc_reg)) >>> 8);
        sm_half = sm_sum >>> 1;
        if (sm_half > 40'sd8388607) begin
            sm_half = 40'sd8388607;
        end else if (sm_half < -40'sd8388608) begin
            sm_half = -40'sd8388608;
        end
    end

    // audio scaling and saturation
    always_comb begin
        o_lim = 40'sd1 <<< (SAMPLE_BITS - 1);
        if (mode_reg) begin
            o_v = (40'(smooth_reg) >>> ENV_SHR) <<< ENV_SHL;
        end else begin
            o_v = (40'(re_reg) - 40'(dc_reg)) >>> SYNC_SHR;
        end
        if (o_v > o_lim - 40'sd1) begin
            o_v = o_lim - 40'sd1;
        end else if (o_v < -o_lim) begin
            o_v = -o_lim;
        end
        o_sat = o_v[SAMPLE_BITS-1:0];
    end

    // configuration and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            freq_low_reg  <= 32'sh8000_0000;
            freq_high_reg <= 32'sh7FFF_FFFF;
            alpha_reg     <= '0;
            beta_reg      <= '0;
            freq_reg      <= '0;
            phase_reg     <= '0;
            dc_reg        <= '0;
            smooth_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MODE:      mode_reg      <= cfg_data[0];
                    CFG_FREQ_INIT: freq_reg      <= $signed(cfg_data);
                    CFG_FREQ_LOW:  freq_low_reg  <= $signed(cfg_data);
                    CFG_FREQ_HIGH: freq_high_reg <= $signed(cfg_data);
                    CFG_ALPHA:     alpha_reg     <= cfg_data;
                    CFG_BETA:      beta_reg      <= cfg_data;
                    default:       ;
                endcase
            end
            if (state_reg == ST_BETA && m_done) begin
                freq_reg <= f_clamp[31:0];
            end
            if (state_reg == ST_ALPHA && m_done) begin
                phase_reg <= phase_reg + step[31:0];
            end
            if (state_reg == ST_DC_ADD) begin
                dc_reg <= dc_sum[31:0];
            end
            if (state_reg == ST_SMOOTH) begin
                smooth_reg <= sm_half[23:0];
            end
        end
    end

    // per-sample payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            si_reg <= $signed({{(XW-SAMPLE_BITS){in_i[SAMPLE_BITS-1]}}, in_i}) <<< IN_SH;
            sq_reg <= $signed({{(XW-SAMPLE_BITS){in_q[SAMPLE_BITS-1]}}, in_q}) <<< IN_SH;
        end
        if (m_done) begin
            unique case (state_reg)
                ST_ROT_X: re_reg   <= XW'(m_r);
                ST_ROT_Y: im_reg   <= XW'(m_r);
                ST_MAG:   mag_reg  <= XW'(m_r);
                ST_DIFF:  diff_reg <= m_r;
                default:  ;
            endcase
        end
        if (state_reg == ST_DC_MUL) begin
            prod_reg <= PW'(dc_d) * PW'($signed({1'b0, dc_gain}));
        end
    end

    // output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            audio_reg <= o_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OW'(audio_reg);

endmodule

[design/amsd_cordic.sv]
`timescale 1ns / 1ps
module amsd_cordic #(
    parameter int STAGES = amsd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  amsd_pkg::cordic_req_t              req,
    input  logic signed [amsd_pkg::XW-1:0]     x_in,
    input  logic signed [amsd_pkg::XW-1:0]     y_in,
    input  logic        [31:0]                 z_in,
    output logic                               done,
    output logic signed [amsd_pkg::XW-1:0]     x_out,
    output logic signed [amsd_pkg::XW-1:0]     y_out,
    output logic        [31:0]                 z_out
);
    import amsd_pkg::*;

    localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 vec_reg;
    logic [IW-1:0]        iter_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    logic                 flip;
    logic signed [XW-1:0] x0, y0;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 dir;
    logic                 last;

    // pre-rotation: fold the vector or angle into right half plane
    always_comb begin
        if (req.vectoring) begin
            flip = x_in[XW-1];
            z0   = flip ? ZW'(34'sh0_8000_0000) : '0;
        end else begin
            flip = z_in[31] ^ z_in[30];
            z0   = ZW'($signed({z_in[31] ^ flip, z_in[30:0]}));
        end
        x0 = flip ? -x_in : x_in;
        y0 = flip ? -y_in : y_in;
    end

    assign xs   = x_reg >>> iter_reg;
    assign ys   = y_reg >>> iter_reg;
    assign at   = $signed({2'b00, atan_word(5'(iter_reg))});
    assign dir  = vec_reg ? y_reg[XW-1] : ~z_reg[ZW-1];
    assign last = (iter_reg == IW'(STAGES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                busy_reg <= !last;
                iter_reg <= last ? '0 : iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            vec_reg <= req.vectoring;
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
        end else if (busy_reg) begin
            if (dir) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg[31:0];

endmodule

[design/amsd_mul.sv]
`timescale 1ns / 1ps
module amsd_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  amsd_pkg::mul_req_t             req,
    input  logic signed [amsd_pkg::MW-1:0] v,
    input  logic        [31:0]             g,
    output logic                           done,
    output logic signed [amsd_pkg::MW-1:0] r
);
    import amsd_pkg::*;

    // sign(v) * floor(|v| * g / 2^s), s = 30 or 32, low half then high half
    logic              busy_reg;
    logic              hi_reg;
    logic              done_reg;
    logic              neg_reg;
    logic              sh30_reg;
    logic [47:0]       m_reg;
    logic [31:0]       g_reg;
    logic [31:0]       lo_reg;
    logic signed [MW-1:0] r_reg;

    logic signed [MW-1:0] vabs;
    logic [31:0]       b_op;
    logic [63:0]       prod;
    logic [64:0]       sum;
    logic [64:0]       mag;
    logic signed [MW-1:0] mag_s;

    assign vabs  = v[MW-1] ? -v : v;
    assign b_op  = hi_reg ? m_reg[47:16] : {16'b0, m_reg[15:0]};
    assign prod  = g_reg * b_op;
    assign sum   = {1'b0, prod} + 65'(lo_reg);
    assign mag   = sh30_reg ? (sum >> 14) : (sum >> 16);
    assign mag_s = $signed(mag[MW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            hi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && hi_reg;
            if (req.start) begin
                busy_reg <= 1'b1;
                hi_reg   <= 1'b0;
            end else if (busy_reg) begin
                busy_reg <= !hi_reg;
                hi_reg   <= !hi_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            m_reg    <= vabs[47:0];
            neg_reg  <= v[MW-1];
            g_reg    <= g;
            sh30_reg <= req.shift30;
        end else if (busy_reg && !hi_reg) begin
            lo_reg <= prod[47:16];
        end else if (busy_reg && hi_reg) begin
            r_reg <= neg_reg ? -mag_s : mag_s;
        end
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

[design/amsd_checker.sv]
`timescale 1ns / 1ps
module amsd_checker #(
    parameter int SAMPLE_BITS = amsd_pkg::SAMPLE_BITS_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata
);
    import amsd_pkg::*;

    // the cycle after a transfer in stays busy
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // a new result only appears after the block was busy
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without work");

    // no result right after a transfer in
    a_no_instant_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind am_sync_demodulator amsd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_amsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
